// ===== hw/rtl/srfl_pkg.sv =====
`default_nettype none

package srfl_pkg;

  // register file geometry
  localparam int NUM_REGS  = 12;
  localparam int MAX_WIDTH = 40;
  localparam int TABLE_LEN = 12;

  // fixed field widths on the ports
  localparam int ADDR_W    = 4;
  localparam int OUT_VAL_W = 40;
  localparam int WIDTH_W   = 7;
  localparam int IDX_W     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // padded stream data widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;

  // request kinds carried on in_tuser
  localparam logic REQ_SHIFT  = 1'b0;
  localparam logic REQ_STROBE = 1'b1;

  typedef logic [MAX_WIDTH-1:0] chain_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [OUT_VAL_W-1:0] out_val_t;

  // one result beat
  typedef struct packed {
    addr_t    address;
    out_val_t value;
    logic     bad;
  } result_t;

  // per-register widths, addresses past the table take the full chain
  function automatic logic [WIDTH_W-1:0] width_of(input addr_t addr);
    logic [WIDTH_W-1:0] w;
    w = WIDTH_W'(MAX_WIDTH);
    if (int'(addr) < TABLE_LEN) begin
      unique case (addr)
        4'd0:    w = WIDTH_W'(16);
        4'd1:    w = WIDTH_W'(40);
        4'd2:    w = WIDTH_W'(20);
        4'd3:    w = WIDTH_W'(28);
        4'd4:    w = WIDTH_W'(28);
        4'd5:    w = WIDTH_W'(32);
        4'd6:    w = WIDTH_W'(32);
        4'd7:    w = WIDTH_W'(32);
        4'd8:    w = WIDTH_W'(32);
        4'd9:    w = WIDTH_W'(13);
        4'd10:   w = WIDTH_W'(28);
        4'd11:   w = WIDTH_W'(2);
        default: w = WIDTH_W'(MAX_WIDTH);
      endcase
    end
    if (int'(w) > MAX_WIDTH) begin
      w = WIDTH_W'(MAX_WIDTH);
    end
    return w;
  endfunction

  // keep the low w bits of the chain
  function automatic chain_t mask_low(input chain_t v, input logic [WIDTH_W-1:0] w);
    chain_t m;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      m[i] = (i < int'(w)) ? v[i] : 1'b0;
    end
    return m;
  endfunction

  // fit a chain value onto the fixed-width output field
  function automatic out_val_t to_out(input chain_t v);
    logic [MAX_WIDTH+OUT_VAL_W-1:0] ext;
    ext = {{OUT_VAL_W{1'b0}}, v};
    return ext[OUT_VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srfl_shift_chain.sv =====
`default_nettype none

module srfl_shift_chain (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift_en,
  input  wire logic            shift_bit,
  output srfl_pkg::chain_t     chain
);

  srfl_pkg::chain_t chain_r;
  srfl_pkg::chain_t chain_nxt;

  // msb first: new bit enters at bit 0
  always_comb begin
    chain_nxt = chain_r;
    if (shift_en) begin
      chain_nxt = {chain_r[srfl_pkg::MAX_WIDTH-2:0], shift_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else begin
      chain_r <= chain_nxt;
    end
  end

  assign chain = chain_r;

endmodule

`default_nettype wire

// ===== hw/rtl/srfl_write_stage.sv =====
`default_nettype none

module srfl_write_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              strobe,
  input  wire srfl_pkg::addr_t   address,
  input  wire srfl_pkg::chain_t  chain,
  output logic                   ready,
  output logic                   res_valid,
  output srfl_pkg::result_t      res,
  input  wire logic              res_ready
);

  srfl_pkg::chain_t  bank_r [srfl_pkg::NUM_REGS];
  srfl_pkg::result_t out_r, out_nxt, skid_r, skid_nxt;
  logic              out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  srfl_pkg::result_t new_res;
  srfl_pkg::chain_t  masked;
  logic              in_range;
  logic              wr_en;
  logic [srfl_pkg::IDX_W-1:0] wr_idx;
  logic              pop;

  // masking and address check
  always_comb begin
    in_range = (int'(address) < srfl_pkg::NUM_REGS);
    masked   = srfl_pkg::mask_low(chain, srfl_pkg::width_of(address));
    new_res.address = address;
    new_res.value   = in_range ? srfl_pkg::to_out(masked) : '0;
    new_res.bad     = !in_range;
    wr_en  = strobe && in_range;
    wr_idx = address[srfl_pkg::IDX_W-1:0];
  end

  // register bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < srfl_pkg::NUM_REGS; i++) begin
        bank_r[i] <= '0;
      end
    end else if (wr_en) begin
      bank_r[wr_idx] <= masked;
    end
  end

  // output register with skid stage
  assign ready = !skid_valid_r;
  assign pop   = out_valid_r && res_ready;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (strobe) begin
      if (!out_valid_r || pop) begin
        out_nxt       = new_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = new_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

  // a held skid beat always sits behind a valid output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid beat without output beat");

  // a flagged address never carries a value
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.bad) |-> (out_r.value == '0))
    else $error("bad address with nonzero value");

  // the bank holds what was just written
  a_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (bank_r[$past(wr_idx)] == $past(masked)))
    else $error("bank entry not written");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== hw/rtl/serial_register_file_loader_core.sv =====
// result: a strobe beat's result is registered onto out_*, or into the skid stage while out_tready stalls
// throughput: one beat per cycle, shift or strobe; a result beat held back by
// out_tready moves into a one-entry skid stage, and in_tready drops only while it is full
// reset: synchronous active-low rst_n clears the shift chain and the register bank
// and empties both output stages
`default_nettype none

module serial_register_file_loader_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [srfl_pkg::IN_DATA_W-1:0]   in_tdata,   // [0] data_bit, [4:1] reg_address, [7:5] zero
  input  wire logic                             in_tuser,   // [0] req_type
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [srfl_pkg::OUT_DATA_W-1:0]       out_tdata,  // [3:0] written_address, [43:4] written_value, [47:44] zero
  output logic                                  out_tuser   // [0] bad_address
);

  logic              in_fire;
  logic              shift_en;
  logic              strobe;
  srfl_pkg::chain_t  chain;
  srfl_pkg::result_t res;

  // beat decode
  assign in_fire  = in_tvalid && in_tready;
  assign shift_en = in_fire && (in_tuser == srfl_pkg::REQ_SHIFT);
  assign strobe   = in_fire && (in_tuser == srfl_pkg::REQ_STROBE);

  srfl_shift_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (shift_en),
    .shift_bit (in_tdata[0]),
    .chain     (chain)
  );

  srfl_write_stage u_write (
    .clk       (clk),
    .rst_n     (rst_n),
    .strobe    (strobe),
    .address   (in_tdata[srfl_pkg::ADDR_W:1]),
    .chain     (chain),
    .ready     (in_tready),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  // result packing
  assign out_tdata = srfl_pkg::OUT_DATA_W'({res.value, res.address});
  assign out_tuser = res.bad;

endmodule

`default_nettype wire
